### rtl/core/gpj_pkg.sv
// Package for the 3D Gaussian profile and Jacobian block: widths, register
// indexes, the exponential table and shared rounding helpers. No dependencies.
package gpj_pkg;

    // Coordinate and coefficient formats
    localparam int CW       = 16;            // coordinate bits, unsigned Q.4
    localparam int DW       = CW + 1;        // signed offset from centre
    localparam int KW       = 20;            // Q4.16 matrix coefficient
    localparam int PW       = 2 * DW;        // offset product d_i*d_j
    localparam int GW       = KW + DW + 2;   // gradient (D d)_i, Q.20
    localparam int PROD_W   = KW + 1 + PW;   // coefficient times product
    localparam int TERM_W   = 61;            // clamped quadratic term
    localparam int QW       = TERM_W + 3;    // sum of six terms
    localparam int CENTRE_W = 48;
    localparam int COEF_W   = 60;

    // Exponential table
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int IDX_W    = $clog2(EXP_TABLE_DEPTH);
    localparam int POS_FRAC = 29;
    localparam int FRAC_W   = POS_FRAC - IDX_W;
    localparam int ROM_W    = 31;
    localparam int EW       = 17;            // e in Q1.16
    localparam longint unsigned EXP_STEP = (64'd16 << 30) / EXP_TABLE_DEPTH;

    // Jacobian products
    localparam int AW       = 32 + EW;       // |A*e|, Q.24
    localparam int BW       = (GW > PW) ? GW : PW;
    localparam int MW       = AW + BW;
    localparam int OW       = 48;
    localparam int NLANE    = 9;

    // Rounding shift of each Jacobian lane: three centre terms, then the
    // matrix terms in output order xx, xy, xz, yy, yz, zz
    localparam int LANE_SHIFT [NLANE] = '{28, 28, 28, 17, 16, 16, 17, 16, 17};

    // Configuration register indexes (byte address 8*index)
    localparam int ADDR_W = 6;
    typedef enum logic [2:0] {
        REG_BACKGROUND = 3'd0,
        REG_AMPLITUDE  = 3'd1,
        REG_CENTRE     = 3'd2,
        REG_DIAG       = 3'd3,
        REG_OFFDIAG    = 3'd4
    } t_reg_idx;

    typedef logic [ROM_W-1:0] t_exp_rom [0:EXP_TABLE_DEPTH];

    // Restoring quotient a/d by shift and subtract, for the table build
    function automatic longint unsigned shift_sub_div(
        input longint unsigned a,
        input longint unsigned d
    );
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], a[b]};
            if (rem >= d) begin
                rem    = rem - d;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Build exp(-k*h) samples in Q.30, h = 16/depth
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom    rom;
        longint unsigned h;
        longint unsigned term;
        longint      sum;
        longint unsigned r;
        logic        done;
        h    = EXP_STEP;
        term = 64'd1 << 30;
        sum  = longint'(term);
        done = 1'b0;
        for (int n = 1; n < 64; n++) begin
            if (!done) begin
                term = shift_sub_div((term * h) >> 30, 64'(n));
                if (term == 0) begin
                    done = 1'b1;
                end else if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
        end
        r = longint'(sum);
        rom[0] = ROM_W'(64'd1 << 30);
        for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
            rom[k] = ROM_W'((64'(rom[k-1]) * r + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

    // Clamp a quadratic term to +-(2^59-1)
    function automatic logic signed [TERM_W-1:0] sat_term(
        input logic signed [PROD_W-1:0] v
    );
        localparam logic signed [PROD_W+59:0] TLIM = {{(PROD_W+1){1'b0}}, {59{1'b1}}};
        logic signed [PROD_W+59:0] vx;
        logic signed [TERM_W-1:0]  res;
        vx = {{60{v[PROD_W-1]}}, v};
        if (vx > TLIM) begin
            res = TLIM[TERM_W-1:0];
        end else if (vx < -TLIM) begin
            res = -TLIM[TERM_W-1:0];
        end else begin
            res = vx[TERM_W-1:0];
        end
        return res;
    endfunction

    // Round magnitude / 2^s half away from zero, apply sign, saturate to 48 bits
    function automatic logic [OW-1:0] round_sat(
        input logic [MW-1:0] m,
        input logic          neg,
        input int            s
    );
        logic [MW:0]   rnd;
        logic [MW:0]   r;
        logic [MW:0]   cap;
        logic [OW-1:0] mag;
        rnd = {1'b0, m} + ((MW+1)'(1) << (s - 1));
        r   = rnd >> s;
        cap = ((MW+1)'(1) << (OW - 1)) - (MW+1)'(!neg);
        if (r > cap) begin
            r = cap;
        end
        mag = r[OW-1:0];
        return neg ? (~mag + OW'(1)) : mag;
    endfunction

endpackage

### rtl/core/gpj_quad.sv
// Offset, products, gradient and quadratic form d'Dd over four register stages.
// Depends on gpj_pkg.
module gpj_quad (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [gpj_pkg::CW-1:0]                i_coord_x,
    input  logic [gpj_pkg::CW-1:0]                i_coord_y,
    input  logic [gpj_pkg::CW-1:0]                i_coord_z,
    input  logic [gpj_pkg::CENTRE_W-1:0]          i_centre,
    input  logic [gpj_pkg::COEF_W-1:0]            i_diag,
    input  logic [gpj_pkg::COEF_W-1:0]            i_offdiag,
    output logic signed [gpj_pkg::QW-1:0]         o_q,
    output logic signed [gpj_pkg::GW-1:0]         o_g [3],
    output logic signed [gpj_pkg::PW-1:0]         o_p [6]
);
    import gpj_pkg::*;

    logic [CW-1:0]              cen [3];
    logic [CW-1:0]              crd [3];
    logic signed [KW-1:0]       kmat [3][3];
    logic signed [KW:0]         kk [6];
    logic signed [KW+DW-1:0]    gm [3][3];
    logic signed [PROD_W-1:0]   tp [6];

    logic signed [DW-1:0]       r_d [3];
    logic signed [PW-1:0]       r_p2 [6];
    logic signed [GW-1:0]       r_g2 [3];
    logic signed [TERM_W-1:0]   r_t3 [6];
    logic signed [PW-1:0]       r_p3 [6];
    logic signed [GW-1:0]       r_g3 [3];
    logic signed [QW-1:0]       r_q4;
    logic signed [PW-1:0]       r_p4 [6];
    logic signed [GW-1:0]       r_g4 [3];

    logic signed [DW-1:0]       n_d [3];
    logic signed [PW-1:0]       n_p [6];
    logic signed [GW-1:0]       n_g [3];
    logic signed [QW-1:0]       n_q;

    // Unpack centre and the symmetric matrix
    always_comb begin
        crd[0] = i_coord_x;
        crd[1] = i_coord_y;
        crd[2] = i_coord_z;
        for (int i = 0; i < 3; i++) begin
            cen[i] = i_centre[CW*i +: CW];
            kmat[i][i] = i_diag[KW*i +: KW];
        end
        kmat[0][1] = i_offdiag[0 +: KW];
        kmat[1][0] = i_offdiag[0 +: KW];
        kmat[0][2] = i_offdiag[KW +: KW];
        kmat[2][0] = i_offdiag[KW +: KW];
        kmat[1][2] = i_offdiag[2*KW +: KW];
        kmat[2][1] = i_offdiag[2*KW +: KW];
        for (int i = 0; i < 3; i++) begin
            kk[i]     = {kmat[i][i][KW-1], kmat[i][i]};
        end
        kk[3] = {kmat[0][1], 1'b0};
        kk[4] = {kmat[0][2], 1'b0};
        kk[5] = {kmat[1][2], 1'b0};
    end

    // Stage 1: offsets from the centre
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i] = DW'({1'b0, crd[i]}) - DW'({1'b0, cen[i]});
        end
    end

    // Stage 2: offset products and gradient
    always_comb begin
        n_p[0] = r_d[0] * r_d[0];
        n_p[1] = r_d[1] * r_d[1];
        n_p[2] = r_d[2] * r_d[2];
        n_p[3] = r_d[0] * r_d[1];
        n_p[4] = r_d[0] * r_d[2];
        n_p[5] = r_d[1] * r_d[2];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                gm[i][j] = kmat[i][j] * r_d[j];
            end
            n_g[i] = GW'(gm[i][0]) + GW'(gm[i][1]) + GW'(gm[i][2]);
        end
    end

    // Stage 3: clamped terms of the quadratic form
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            tp[i] = kk[i] * r_p2[i];
        end
    end

    // Stage 4: sum of the six terms
    always_comb begin
        n_q = '0;
        for (int i = 0; i < 6; i++) begin
            n_q = n_q + QW'(r_t3[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d  <= n_d;
            r_p2 <= n_p;
            r_g2 <= n_g;
            for (int i = 0; i < 6; i++) begin
                r_t3[i] <= sat_term(tp[i]);
            end
            r_p3 <= r_p2;
            r_g3 <= r_g2;
            r_q4 <= n_q;
            r_p4 <= r_p3;
            r_g4 <= r_g3;
        end
    end

    assign o_q = r_q4;
    assign o_g = r_g4;
    assign o_p = r_p4;

endmodule

### rtl/core/gpj_exp.sv
// Table exponential e = exp(-q/2^25) with linear interpolation, two stages.
// Depends on gpj_pkg for the table and widths.
module gpj_exp (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [gpj_pkg::QW-1:0] i_q,
    output logic [gpj_pkg::EW-1:0]        o_e
);
    import gpj_pkg::*;

    logic [IDX_W-1:0]           idx;
    logic [ROM_W-1:0]           ti;
    logic [ROM_W-1:0]           ti1;
    logic [ROM_W+FRAC_W-1:0]    prod;
    logic [ROM_W-1:0]           e30;
    logic [ROM_W:0]             e_rnd;

    logic [ROM_W-1:0]           r_ti;
    logic [ROM_W-1:0]           r_diff;
    logic [FRAC_W-1:0]          r_frac;
    logic                       r_one;
    logic                       r_zero;
    logic [EW-1:0]              r_e;
    logic [EW-1:0]              n_e;

    // Stage 1: range checks and table reads
    always_comb begin
        idx = i_q[POS_FRAC-1 -: IDX_W];
        ti  = EXP_ROM[{1'b0, idx}];
        ti1 = EXP_ROM[{1'b0, idx} + (IDX_W+1)'(1)];
    end

    // Stage 2: interpolate and round to Q1.16
    always_comb begin
        prod  = r_diff * r_frac;
        e30   = r_ti - ROM_W'(prod >> FRAC_W);
        e_rnd = {1'b0, e30} + (ROM_W+1)'(1 << 13);
        if (r_one) begin
            n_e = EW'(1 << 16);
        end else if (r_zero) begin
            n_e = '0;
        end else begin
            n_e = e_rnd[14 +: EW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ti   <= ti;
            r_diff <= ti - ti1;
            r_frac <= i_q[FRAC_W-1:0];
            r_one  <= i_q[QW-1] || (i_q == '0);
            r_zero <= !i_q[QW-1] && (|i_q[QW-2:POS_FRAC]);
            r_e    <= n_e;
        end
    end

    assign o_e = r_e;

endmodule

### rtl/core/gpj_wmul.sv
// Two-stage unsigned multiplier for |A*e| times a gradient or product magnitude.
// Depends on gpj_pkg for operand widths.
module gpj_wmul (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [gpj_pkg::AW-1:0] i_a,
    input  logic [gpj_pkg::BW-1:0] i_b,
    output logic [gpj_pkg::MW-1:0] o_m
);
    import gpj_pkg::*;

    localparam int ALO = (AW + 1) / 2;
    localparam int AHI = AW - ALO;
    localparam int BLO = (BW + 1) / 2;
    localparam int BHI = BW - BLO;

    logic [ALO+BLO-1:0] r_p00;
    logic [ALO+BHI-1:0] r_p01;
    logic [AHI+BLO-1:0] r_p10;
    logic [AHI+BHI-1:0] r_p11;
    logic [MW-1:0]      r_m;

    // Stage 1: four partial products; stage 2: align and add
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= i_a[ALO-1:0] * i_b[BLO-1:0];
            r_p01 <= i_a[ALO-1:0] * i_b[BW-1:BLO];
            r_p10 <= i_a[AW-1:ALO] * i_b[BLO-1:0];
            r_p11 <= i_a[AW-1:ALO] * i_b[BW-1:BLO];
            r_m   <= MW'(r_p00) + (MW'(r_p01) << BLO) + (MW'(r_p10) << ALO)
                   + (MW'(r_p11) << (ALO + BLO));
        end
    end

    assign o_m = r_m;

endmodule

### rtl/core/gaussian_profile_3d_jacobian.sv
// Top level of the 3D Gaussian profile and Jacobian pipeline with its register port.
// Depends on gpj_pkg, gpj_quad, gpj_exp and gpj_wmul.
//
// One voxel coordinate enters per cycle, and its profile value, exponential and nine
// Jacobian terms leave through a ten-stage pipeline: four stages form the offset, its
// products and the quadratic form, two evaluate the table exponential, one forms A*e,
// two split each wide Jacobian product into partial products, and the last rounds and
// saturates into the output register. Throughput is one item per cycle; a stall at the
// output holds the whole pipeline, and input stall follows it. Registers sit at byte
// addresses 8*index on the 64-bit port; the user must write them only while no item is
// in flight, and the block itself does not enforce this.
module gaussian_profile_3d_jacobian (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [gpj_pkg::CW-1:0]          i_coord_x,
    input  logic [gpj_pkg::CW-1:0]          i_coord_y,
    input  logic [gpj_pkg::CW-1:0]          i_coord_z,
    // result items
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [gpj_pkg::OW-1:0]   o_profile_value,
    output logic [gpj_pkg::EW-1:0]          o_exp_term,
    output logic signed [gpj_pkg::OW-1:0]   o_d_centre_x,
    output logic signed [gpj_pkg::OW-1:0]   o_d_centre_y,
    output logic signed [gpj_pkg::OW-1:0]   o_d_centre_z,
    output logic signed [gpj_pkg::OW-1:0]   o_d_coef_xx,
    output logic signed [gpj_pkg::OW-1:0]   o_d_coef_xy,
    output logic signed [gpj_pkg::OW-1:0]   o_d_coef_xz,
    output logic signed [gpj_pkg::OW-1:0]   o_d_coef_yy,
    output logic signed [gpj_pkg::OW-1:0]   o_d_coef_yz,
    output logic signed [gpj_pkg::OW-1:0]   o_d_coef_zz,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gpj_pkg::ADDR_W-1:0]      paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);
    import gpj_pkg::*;

    localparam int NSTAGE = 10;

    // Configuration registers
    logic [31:0]            r_bg;
    logic [31:0]            r_amp;
    logic [CENTRE_W-1:0]    r_centre;
    logic [COEF_W-1:0]      r_diag;
    logic [COEF_W-1:0]      r_off;
    t_reg_idx               reg_idx;
    logic                   wr_en;

    // Pipeline control
    logic [NSTAGE-1:0]      r_vld;
    logic                   en;

    // Datapath
    logic signed [QW-1:0]   q4;
    logic signed [GW-1:0]   g4 [3];
    logic signed [PW-1:0]   p4 [6];
    logic [EW-1:0]          e6;
    logic [BW-1:0]          bm4 [NLANE];
    logic                   bn4 [NLANE];
    logic [BW-1:0]          r_bm5 [NLANE];
    logic [BW-1:0]          r_bm6 [NLANE];
    logic [BW-1:0]          r_bm7 [NLANE];
    logic                   r_bn5 [NLANE];
    logic                   r_bn6 [NLANE];
    logic                   r_neg7 [NLANE];
    logic                   r_neg8 [NLANE];
    logic                   r_neg9 [NLANE];
    logic [MW-1:0]          m9 [NLANE];
    logic [31:0]            amp_mag;
    logic [AW-1:0]          ae_prod;
    logic [AW-1:0]          r_ae_mag7;
    logic                   r_ae_neg7;
    logic [AW:0]            ae_rnd;
    logic [OW-1:0]          prof_ae;
    logic [EW-1:0]          r_e7;
    logic [EW-1:0]          r_e8;
    logic [EW-1:0]          r_e9;
    logic [OW-1:0]          r_prof8;
    logic [OW-1:0]          r_prof9;
    logic [OW-1:0]          r_out_prof;
    logic [EW-1:0]          r_out_e;
    logic [OW-1:0]          r_out_j [NLANE];

    // Register port
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg     <= '0;
            r_amp    <= 32'd256;
            r_centre <= '0;
            r_diag   <= '0;
            r_off    <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BACKGROUND: r_bg     <= pwdata[31:0];
                REG_AMPLITUDE:  r_amp    <= pwdata[31:0];
                REG_CENTRE:     r_centre <= pwdata[CENTRE_W-1:0];
                REG_DIAG:       r_diag   <= pwdata[COEF_W-1:0];
                REG_OFFDIAG:    r_off    <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BACKGROUND: prdata = 64'(r_bg);
            REG_AMPLITUDE:  prdata = 64'(r_amp);
            REG_CENTRE:     prdata = 64'(r_centre);
            REG_DIAG:       prdata = 64'(r_diag);
            REG_OFFDIAG:    prdata = 64'(r_off);
            default:        prdata = '0;
        endcase
    end

    // Hold every stage while a finished item waits at the output
    assign en      = !(r_vld[NSTAGE-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_valid};
        end
    end

    gpj_quad u_quad (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .i_coord_z (i_coord_z),
        .i_centre  (r_centre),
        .i_diag    (r_diag),
        .i_offdiag (r_off),
        .o_q       (q4),
        .o_g       (g4),
        .o_p       (p4)
    );

    gpj_exp u_exp (
        .i_clk (i_clk),
        .i_en  (en),
        .i_q   (q4),
        .o_e   (e6)
    );

    // Lane operands: centre terms take the gradient, matrix terms take -d_i*d_j
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bm4[i] = BW'(g4[i][GW-1] ? GW'(-g4[i]) : GW'(g4[i]));
            bn4[i] = g4[i][GW-1];
        end
        // output order xx, xy, xz, yy, yz, zz from product order xx, yy, zz, xy, xz, yz
        bm4[3] = BW'(p4[0][PW-1] ? PW'(-p4[0]) : PW'(p4[0]));
        bm4[4] = BW'(p4[3][PW-1] ? PW'(-p4[3]) : PW'(p4[3]));
        bm4[5] = BW'(p4[4][PW-1] ? PW'(-p4[4]) : PW'(p4[4]));
        bm4[6] = BW'(p4[1][PW-1] ? PW'(-p4[1]) : PW'(p4[1]));
        bm4[7] = BW'(p4[5][PW-1] ? PW'(-p4[5]) : PW'(p4[5]));
        bm4[8] = BW'(p4[2][PW-1] ? PW'(-p4[2]) : PW'(p4[2]));
        bn4[3] = !p4[0][PW-1] && (p4[0] != '0);
        bn4[4] = !p4[3][PW-1] && (p4[3] != '0);
        bn4[5] = !p4[4][PW-1] && (p4[4] != '0);
        bn4[6] = !p4[1][PW-1] && (p4[1] != '0);
        bn4[7] = !p4[5][PW-1] && (p4[5] != '0);
        bn4[8] = !p4[2][PW-1] && (p4[2] != '0);
    end

    // A*e magnitude, and the profile from it rounded to Q.16
    always_comb begin
        amp_mag = r_amp[31] ? (~r_amp + 32'd1) : r_amp;
        ae_prod = amp_mag * e6;
        ae_rnd  = {1'b0, r_ae_mag7} + (AW+1)'(128);
        prof_ae = OW'(ae_rnd[AW:8]);
        if (r_ae_neg7) begin
            prof_ae = ~prof_ae + OW'(1);
        end
    end

    // Advance side data alongside the exponential and the wide products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bm5     <= bm4;
            r_bn5     <= bn4;
            r_bm6     <= r_bm5;
            r_bn6     <= r_bn5;
            r_bm7     <= r_bm6;
            for (int j = 0; j < NLANE; j++) begin
                r_neg7[j] <= r_amp[31] ^ r_bn6[j];
            end
            r_ae_mag7 <= ae_prod;
            r_ae_neg7 <= r_amp[31];
            r_e7      <= e6;
            r_e8      <= r_e7;
            r_e9      <= r_e8;
            r_neg8    <= r_neg7;
            r_neg9    <= r_neg8;
            r_prof8   <= OW'({{8{r_bg[31]}}, r_bg, 8'd0}) + prof_ae;
            r_prof9   <= r_prof8;
        end
    end

    for (genvar j = 0; j < NLANE; j++) begin : g_lane
        gpj_wmul u_wmul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_ae_mag7),
            .i_b   (r_bm7[j]),
            .o_m   (m9[j])
        );
    end

    // Output register: round, saturate and sign each lane
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_prof <= r_prof9;
            r_out_e    <= r_e9;
            for (int j = 0; j < NLANE; j++) begin
                r_out_j[j] <= round_sat(m9[j], r_neg9[j], LANE_SHIFT[j]);
            end
        end
    end

    assign o_profile_value = r_out_prof;
    assign o_exp_term      = r_out_e;
    assign o_d_centre_x    = r_out_j[0];
    assign o_d_centre_y    = r_out_j[1];
    assign o_d_centre_z    = r_out_j[2];
    assign o_d_coef_xx     = r_out_j[3];
    assign o_d_coef_xy     = r_out_j[4];
    assign o_d_coef_xz     = r_out_j[5];
    assign o_d_coef_yy     = r_out_j[6];
    assign o_d_coef_yz     = r_out_j[7];
    assign o_d_coef_zz     = r_out_j[8];

endmodule
